[sv/utf8_stream_decoder_macros.svh]
// Assertion macros shared by the UTF-8 stream decoder RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define AST_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define AST_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[sv/u8sd_pkg.sv]
// Types, constants and decode functions of the UTF-8 stream decoder.
// No dependencies; used by the front end, the back end and the top level.
package u8sd_pkg;

   localparam logic [20:0] ReplCp            = 21'h00FFFD;
   localparam int          QueueDepthDefault = 2;
   localparam int          WindowDepth       = 4;

   // Sequence lengths taken from the lead byte
   localparam logic [2:0] LenBad = 3'd0;
   localparam logic [2:0] Len1   = 3'd1;
   localparam logic [2:0] Len2   = 3'd2;
   localparam logic [2:0] Len3   = 3'd3;
   localparam logic [2:0] Len4   = 3'd4;

   typedef struct packed {
      logic [2:0] len;   // length if taken as a lead, LenBad if not a lead
      logic       cont;  // byte has the form 10xxxxxx
   } class_type;

   typedef struct packed {
      logic [7:0] data;
      logic       fin;
      class_type  cls;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } queue_type;

   typedef struct packed {
      logic [7:0] data;
      class_type  cls;
   } slot_type;

   typedef slot_type [WindowDepth-1:0] window_type;

   typedef struct packed {
      logic        emit;
      logic [20:0] cp;
      logic        err;
      logic [2:0]  used;
   } result_type;

   function automatic class_type classify(input logic [7:0] data);
      class_type c;
      c.cont = (data & 8'hC0) == 8'h80;
      if (data < 8'h80) begin
         c.len = Len1;
      end else if (data inside {[8'hC0:8'hDF]}) begin
         c.len = Len2;
      end else if (data inside {[8'hE0:8'hEF]}) begin
         c.len = Len3;
      end else if (data inside {[8'hF0:8'hF7]}) begin
         c.len = Len4;
      end else begin
         c.len = LenBad;
      end
      return c;
   endfunction

   function automatic logic [7:0] lead_mask(input logic [2:0] len);
      logic [7:0] m;
      case (len)
         Len1:    m = 8'h7F;
         Len2:    m = 8'h1F;
         Len3:    m = 8'h0F;
         Len4:    m = 8'h07;
         default: m = 8'h00;
      endcase
      return m;
   endfunction

   // Settle the sequence at the head of the window, if it can be settled.
   function automatic result_type evaluate(input window_type win,
                                           input logic [2:0] count,
                                           input logic fin);
      result_type  r;
      logic [2:0]  len;
      logic [2:0]  bad;
      logic [20:0] cp;
      len = win[0].cls.len;
      bad = 3'd0;
      cp  = {13'b0, win[0].data & lead_mask(len)};
      for (int i = 1; i < WindowDepth; i++) begin
         if (3'(i) < len) begin
            cp = {cp[14:0], win[i].data[5:0]};
         end
      end
      // Scan down so the first bad continuation wins
      for (int i = WindowDepth - 1; i >= 1; i--) begin
         if (3'(i) < len && !win[i].cls.cont) begin
            bad = 3'(i);
         end
      end
      r.emit = 1'b0;
      r.cp   = ReplCp;
      r.err  = 1'b1;
      r.used = 3'd1;
      if (count == 3'd0) begin
         r.emit = 1'b0;
      end else if (len == LenBad) begin
         r.emit = 1'b1;
      end else if (count < len) begin
         r.emit = fin;
      end else if (bad != 3'd0) begin
         r.emit = 1'b1;
         r.used = bad;
      end else begin
         r.emit = 1'b1;
         r.cp   = cp;
         r.err  = 1'b0;
         r.used = len;
      end
      return r;
   endfunction

   // Drop n bytes from the front of the window.
   function automatic window_type shift_window(input window_type w, input logic [2:0] n);
      window_type s;
      logic [2:0] idx;
      s = w;
      for (int k = 0; k < WindowDepth; k++) begin
         idx = 3'(k) + n;
         if (idx < 3'(WindowDepth)) begin
            s[k] = w[idx[1:0]];
         end
      end
      return s;
   endfunction

endpackage

[sv/u8sd_ifs.sv]
// Valid/ready channel interfaces of the UTF-8 stream decoder.
// No dependencies; the request carries bytes, the response code points.
interface u8sd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       stream_end;

   modport source (output valid, output in_byte, output stream_end, input ready);
   modport sink   (input valid, input in_byte, input stream_end, output ready);
endinterface

interface u8sd_rsp_if;
   logic        valid;
   logic        ready;
   logic [20:0] code_point;
   logic        is_error;
   logic [2:0]  bytes_used;
   logic        last_of_run;

   modport source (output valid, output code_point, output is_error,
                   output bytes_used, output last_of_run, input ready);
   modport sink   (input valid, input code_point, input is_error,
                   input bytes_used, input last_of_run, output ready);
endinterface

[sv/u8sd_front.sv]
// Front end: accepts bytes, classifies them and queues them for the back end.
// Depends on u8sd_pkg and u8sd_req_if.
`include "utf8_stream_decoder_macros.svh"

module u8sd_front #(
   parameter int QueueDepth = u8sd_pkg::QueueDepthDefault
) (
   input  logic                clock,
   input  logic                reset,
   u8sd_req_if.sink            req,
   input  logic                q_pop,
   output u8sd_pkg::queue_type q_head
);

   localparam int PtrWidth  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int FillWidth = $clog2(QueueDepth + 1);
   localparam logic [PtrWidth-1:0]  LastPtr  = PtrWidth'(QueueDepth - 1);
   localparam logic [FillWidth-1:0] FullFill = FillWidth'(QueueDepth);

   u8sd_pkg::entry_type  q_mem_ff [QueueDepth];
   u8sd_pkg::entry_type  new_entry;
   logic [PtrWidth-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FillWidth-1:0] fill_ff, fill_in;
   logic                 push;

   assign req.ready = fill_ff != FullFill;
   assign push      = req.valid && req.ready;

   always_comb begin
      new_entry.data = req.in_byte;
      new_entry.fin  = req.stream_end;
      new_entry.cls  = u8sd_pkg::classify(req.in_byte);
   end

   assign q_head.valid = fill_ff != '0;
   assign q_head.entry = q_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (q_pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= new_entry;
      end
   end

   `AST_IMPLIES(a_fill_bound, clock, reset, 1'b1, fill_ff <= FullFill)
   `AST_IMPLIES(a_pop_nonempty, clock, reset, q_pop, fill_ff != '0)
   `AST_NEXT(a_fill_grows, clock, reset, push && !q_pop, fill_ff == $past(fill_ff) + 1'b1)

endmodule

[sv/u8sd_back.sv]
// Back end: holds the byte window, drives results, settles one sequence per cycle while the output is free.
// Depends on u8sd_pkg and u8sd_rsp_if.
`include "utf8_stream_decoder_macros.svh"

module u8sd_back (
   input  logic                clock,
   input  logic                reset,
   input  u8sd_pkg::queue_type q_head,
   output logic                q_pop,
   u8sd_rsp_if.source          rsp
);

   u8sd_pkg::window_type win_ff, win_in;
   u8sd_pkg::window_type shifted;
   u8sd_pkg::result_type res, more;
   logic [2:0]  count_ff, count_in, rest_count;
   logic        busy_ff, busy_in;
   logic        fin_ff, fin_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [20:0] cp_ff, cp_in;
   logic        err_ff, err_in;
   logic [2:0]  used_ff, used_in;
   logic        last_ff, last_in;
   logic        out_free, step, load;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign step     = busy_ff && out_free;
   assign q_pop    = !busy_ff && q_head.valid;

   always_comb begin
      res        = u8sd_pkg::evaluate(win_ff, count_ff, fin_ff);
      shifted    = u8sd_pkg::shift_window(win_ff, res.used);
      rest_count = count_ff - res.used;
      more       = u8sd_pkg::evaluate(shifted, rest_count, fin_ff);
   end

   assign load = step && res.emit;

   always_comb begin
      win_in   = win_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      fin_in   = fin_ff;
      if (q_pop) begin
         // append at the tail; idle window holds at most three bytes
         win_in[count_ff[1:0]].data = q_head.entry.data;
         win_in[count_ff[1:0]].cls  = q_head.entry.cls;
         count_in = count_ff + 3'd1;
         fin_in   = q_head.entry.fin;
         busy_in  = 1'b1;
      end else if (step) begin
         if (res.emit) begin
            win_in   = shifted;
            count_in = rest_count;
            busy_in  = more.emit;
         end else begin
            busy_in = 1'b0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      cp_in        = cp_ff;
      err_in       = err_ff;
      used_in      = used_ff;
      last_in      = last_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         cp_in        = res.cp;
         err_in       = res.err;
         used_in      = res.used;
         last_in      = !more.emit;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         fin_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         fin_ff       <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff  <= win_in;
      cp_ff   <= cp_in;
      err_ff  <= err_in;
      used_ff <= used_in;
      last_ff <= last_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.code_point  = cp_ff;
   assign rsp.is_error    = err_ff;
   assign rsp.bytes_used  = used_ff;
   assign rsp.last_of_run = last_ff;

   `AST_IMPLIES(a_idle_window_short, clock, reset, !busy_ff, count_ff <= 3'd3)
   `AST_IMPLIES(a_final_byte_empties, clock, reset, !busy_ff && fin_ff, count_ff == 3'd0)
   `AST_IMPLIES(a_used_in_window, clock, reset, load,
                res.used != 3'd0 && res.used <= count_ff)

endmodule

[sv/utf8_stream_decoder.sv]
// Path: a byte that completes a sequence goes through the byte queue, the window and the
//   output register before its first result is valid; that result transfers once the
//   receiver is ready.
// Flow: the back end appends a byte to its window, then settles its results in turn while
//   its output is free, or finds that the byte only waits, and then takes the next byte.
// Reset: synchronous, active high; empties the queue and the window and drops any result.
module utf8_stream_decoder #(
   parameter int QueueDepth = u8sd_pkg::QueueDepthDefault
) (
   input  logic       clock,
   input  logic       reset,
   u8sd_req_if.sink   req_chan,
   u8sd_rsp_if.source rsp_chan
);

   // Head of the byte queue, and the back end's request to advance it
   u8sd_pkg::queue_type q_head;
   logic                q_pop;

   // Front: transfer bytes in, tag each as lead length and continuation, queue them
   u8sd_front #(
      .QueueDepth (QueueDepth)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_chan),
      .q_pop  (q_pop),
      .q_head (q_head)
   );

   // Back: hold up to four pending bytes, settle one sequence per cycle while the output
   // register is free, and hold each result in that register until its transfer
   u8sd_back u_back (
      .clock  (clock),
      .reset  (reset),
      .q_head (q_head),
      .q_pop  (q_pop),
      .rsp    (rsp_chan)
   );

endmodule

[verif/utf8_stream_decoder_tb.sv]
// Self-checking testbench of utf8_stream_decoder: directed and random byte streams.
// Depends on u8sd_pkg and on the request/response channel interfaces in u8sd_ifs.sv.
module utf8_stream_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // One decoded result as it leaves the response channel
   typedef struct packed {
      logic [20:0] code_point;
      logic        is_error;
      logic [2:0]  bytes_used;
      logic        last_of_run;
   } decoded_type;

   logic clock;
   logic reset;

   u8sd_req_if req_if ();
   u8sd_rsp_if rsp_if ();

   utf8_stream_decoder DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // Code points still owed by the block, oldest first
   decoded_type due_code_points [$];
   // Private copy of the byte window: bytes that wait for their sequence to settle
   logic [7:0]  held_bytes [4];
   int unsigned held_count  = 0;
   int          error_count = 0;
   // Percent of cycles in which the sender holds back and the receiver stalls
   int          gap_pct     = 0;
   int          stall_pct   = 0;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Sequence length implied by a lead byte; LenBad for anything that cannot lead
   function automatic logic [2:0] lead_length(input logic [7:0] b);
      if (b <= 8'h7F) return u8sd_pkg::Len1;
      if (b >= 8'hC0 && b <= 8'hDF) return u8sd_pkg::Len2;
      if (b >= 8'hE0 && b <= 8'hEF) return u8sd_pkg::Len3;
      if (b >= 8'hF0 && b <= 8'hF7) return u8sd_pkg::Len4;
      return u8sd_pkg::LenBad;
   endfunction

   // Payload bits that a lead byte of the given length contributes
   function automatic logic [7:0] payload_mask(input logic [2:0] len);
      case (len)
         u8sd_pkg::Len1: return 8'h7F;
         u8sd_pkg::Len2: return 8'h1F;
         u8sd_pkg::Len3: return 8'h0F;
         u8sd_pkg::Len4: return 8'h07;
         default:        return 8'h00;
      endcase
   endfunction

   // Drop n bytes from the front of the window
   function automatic void drop_held(input int unsigned n);
      if (n >= held_count) begin
         held_count = 0;
         return;
      end
      for (int k = 0; k + n < held_count; k++) begin
         held_bytes[k] = held_bytes[k + n];
      end
      held_count -= n;
   endfunction

   // Append one accepted byte to the window, settle what can be settled and
   // queue the code points that this byte releases.
   function automatic void decode_byte(input logic [7:0] b, input logic fin);
      decoded_type run [$];
      decoded_type r;
      logic [2:0]  len;
      logic [20:0] acc;
      int unsigned bad;
      if (held_count >= 4) held_count = 0;
      held_bytes[held_count] = b;
      held_count++;
      while (held_count > 0 && run.size() < 4) begin
         len = lead_length(held_bytes[0]);
         // Hold an incomplete sequence unless the stream ends here
         if (len != u8sd_pkg::LenBad && held_count < len && !fin) break;
         // Invalid lead and cut-short lead both cost one byte and one replacement
         r = '{code_point: u8sd_pkg::ReplCp, is_error: 1'b1, bytes_used: 3'd1,
               last_of_run: 1'b0};
         if (len != u8sd_pkg::LenBad && held_count >= len) begin
            acc = {13'b0, held_bytes[0] & payload_mask(len)};
            bad = 0;
            for (int i = 1; i < len; i++) begin
               if (bad == 0) begin
                  if (held_bytes[i][7:6] != 2'b10) bad = i;
                  else acc = {acc[14:0], held_bytes[i][5:0]};
               end
            end
            if (bad != 0) begin
               // Replace the bytes before the offender, which then leads anew
               r.bytes_used = 3'(bad);
            end else begin
               r.code_point = acc;
               r.is_error   = 1'b0;
               r.bytes_used = len;
            end
         end
         run.push_back(r);
         drop_held(r.bytes_used);
      end
      if (run.size() > 0) run[run.size() - 1].last_of_run = 1'b1;
      foreach (run[k]) due_code_points.push_back(run[k]);
   endfunction

   function automatic void check_field(input string name, input logic [20:0] want,
                                       input logic [20:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         error_count++;
      end
   endfunction

   // Receiver: decide ready afresh at every edge
   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
   end

   // Compare every transfer on the response channel with the oldest code point owed
   always @(posedge clock) begin
      decoded_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (due_code_points.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual cp %h err %b used %0d",
                     $time, rsp_if.code_point, rsp_if.is_error, rsp_if.bytes_used);
            error_count++;
         end else begin
            want = due_code_points.pop_front();
            check_field("code_point", want.code_point, rsp_if.code_point);
            check_field("is_error", 21'(want.is_error), 21'(rsp_if.is_error));
            check_field("bytes_used", 21'(want.bytes_used), 21'(rsp_if.bytes_used));
            check_field("last_of_run", 21'(want.last_of_run), 21'(rsp_if.last_of_run));
         end
      end
   end

   // Offer one byte, hold it until the transfer, then predict its results.
   // Valid stays high on exit so back-to-back bytes need no second assignment.
   task automatic transfer_byte(input logic [7:0] b, input logic fin);
      while ($urandom_range(99) < gap_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.in_byte    <= b;
      req_if.stream_end <= fin;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      decode_byte(b, fin);
   endtask

   // ASCII extremes
   task automatic test_single_bytes();
      transfer_byte(8'h00, 1'b0);
      transfer_byte(8'h7F, 1'b0);
   endtask

   // Well-formed multibyte sequences, overlong and surrogate forms included
   task automatic test_multibyte();
      // replacement character carried as data, not an error
      transfer_byte(8'hEF, 1'b0);
      transfer_byte(8'hBF, 1'b0);
      transfer_byte(8'hBD, 1'b0);
      // largest value a four-byte form can carry; stream ends on a complete sequence
      transfer_byte(8'hF7, 1'b0);
      transfer_byte(8'hBF, 1'b0);
      transfer_byte(8'hBF, 1'b0);
      transfer_byte(8'hBF, 1'b1);
      // overlong NUL
      transfer_byte(8'hC0, 1'b0);
      transfer_byte(8'h80, 1'b0);
      // high surrogate
      transfer_byte(8'hED, 1'b0);
      transfer_byte(8'hA0, 1'b0);
      transfer_byte(8'h80, 1'b0);
   endtask

   // Bytes that can never lead: lone continuations and the F8-FF range
   task automatic test_invalid_leads();
      transfer_byte(8'h80, 1'b0);
      transfer_byte(8'hFF, 1'b0);
      transfer_byte(8'hF8, 1'b0);
   endtask

   task automatic test_bad_continuations();
      // four-byte lead broken at the first continuation: four results from one byte
      transfer_byte(8'hF0, 1'b0);
      transfer_byte(8'h41, 1'b0);
      transfer_byte(8'h42, 1'b0);
      transfer_byte(8'h43, 1'b0);
      // three-byte lead broken at the second continuation
      transfer_byte(8'hE2, 1'b0);
      transfer_byte(8'h82, 1'b0);
      transfer_byte(8'h21, 1'b0);
   endtask

   // Stream ends in the middle of a sequence: one replacement per byte
   task automatic test_cut_short();
      transfer_byte(8'hE2, 1'b0);
      transfer_byte(8'h82, 1'b1);
   endtask

   // Mostly well-formed sequences with random payload; the rest is noise,
   // corrupted sequences and sequences cut short.
   task automatic send_random_text(input int n_bytes);
      logic [7:0] seq [4];
      int         seq_len;
      int         n_send;
      int         kind;
      int         sent;
      logic       fin;
      sent = 0;
      while (sent < n_bytes) begin
         kind    = $urandom_range(99);
         seq_len = $urandom_range(4, 1);
         case (seq_len)
            1:       seq[0] = 8'($urandom_range(8'h7F, 8'h00));
            2:       seq[0] = 8'($urandom_range(8'hDF, 8'hC0));
            3:       seq[0] = 8'($urandom_range(8'hEF, 8'hE0));
            default: seq[0] = 8'($urandom_range(8'hF7, 8'hF0));
         endcase
         for (int i = 1; i < 4; i++) begin
            seq[i] = {2'b10, 6'($urandom)};
         end
         n_send = seq_len;
         if (kind < 12) begin
            // lone random byte
            seq[0] = 8'($urandom);
            n_send = 1;
         end else if (kind < 20) begin
            // corrupt one byte of the sequence
            seq[$urandom_range(seq_len - 1, 0)] = 8'($urandom);
         end else if (kind < 30 && seq_len > 1) begin
            // truncate: the next lead or the stream end breaks it
            n_send = $urandom_range(seq_len - 1, 1);
         end
         for (int i = 0; i < n_send; i++) begin
            fin = (i == n_send - 1) && ($urandom_range(n_send < seq_len ? 1 : 9) == 0);
            transfer_byte(seq[i], fin);
         end
         sent += n_send;
      end
   endtask

   // Random text under each mix of sender gaps and receiver stalls
   task automatic test_random_text();
      gap_pct   = 0;
      stall_pct = 0;
      send_random_text(64);
      gap_pct   = 64;
      stall_pct = 0;
      send_random_text(64);
      gap_pct   = 0;
      stall_pct = 64;
      send_random_text(64);
      gap_pct   = 6;
      stall_pct = 6;
      send_random_text(64);
   endtask

   initial begin
      reset             <= 1'b1;
      req_if.valid      <= 1'b0;
      req_if.in_byte    <= 8'h00;
      req_if.stream_end <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_single_bytes();
      test_multibyte();
      test_invalid_leads();
      test_bad_continuations();
      test_cut_short();
      test_random_text();

      // Drop valid after the last transfer, drain, then watch for stray results
      req_if.valid <= 1'b0;
      stall_pct = 0;
      while (due_code_points.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      if (error_count == 0 && due_code_points.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Hang guard, far beyond the slowest legal run
   initial begin
      #3_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

[sim.f]
+incdir+sv
sv/u8sd_pkg.sv
sv/u8sd_ifs.sv
sv/u8sd_front.sv
sv/u8sd_back.sv
sv/utf8_stream_decoder.sv
verif/utf8_stream_decoder_tb.sv
